[src/drc_pkg.sv]
// ----------------------------------------------------------------------------
// drc_pkg
// Types, constants and CRC-8 helpers for the digit record codec.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned NumDigits = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned RecW      = 64;
  localparam int unsigned DataW     = NumDigits * ByteW;

  localparam logic [ByteW-1:0] RecMarker = 8'hA5;
  localparam logic [ByteW-1:0] CrcPoly   = 8'h07;
  localparam logic [ByteW-1:0] DigitMax  = 8'd9;
  localparam logic [RecW-1:0]  RecErased = '1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadArg    = 3'd1,
    StErased    = 3'd2,
    StBadMarker = 3'd3,
    StBadDigit  = 3'd4,
    StBadCrc    = 3'd5
  } status_e;

  typedef logic [NumDigits-1:0][ByteW-1:0]  digits_t;
  typedef logic [NumDigits-1:0][DigitW-1:0] out_digits_t;

  typedef struct packed {
    logic            mode;
    digits_t         digit;
    logic [RecW-1:0] record_in;
  } in_t;

  typedef struct packed {
    logic [RecW-1:0] record_out;
    status_e         status;
    out_digits_t     digit;
  } res_t;

  typedef logic [ByteW-1:0] crc_col_t [DataW];

  function automatic logic [ByteW-1:0] crc8_byte(logic [ByteW-1:0] acc, logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = acc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [ByteW-1:0] crc8_msg(digits_t d, logic [ByteW-1:0] marker);
    logic [ByteW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NumDigits; i++) begin
      acc = crc8_byte(acc, d[i]);
    end
    acc = crc8_byte(acc, marker);
    return acc;
  endfunction

  // Contribution of each single data bit to the CRC (the code is linear).
  function automatic crc_col_t crc8_cols();
    crc_col_t cols;
    digits_t  d;
    for (int j = 0; j < DataW; j++) begin
      d       = digits_t'({{(DataW-1){1'b0}}, 1'b1} << j);
      cols[j] = crc8_msg(d, '0);
    end
    return cols;
  endfunction

  localparam crc_col_t         CrcCols       = crc8_cols();
  localparam logic [ByteW-1:0] CrcMarkerTerm = crc8_msg('0, RecMarker);

endpackage

[src/drc_in_if.sv]
// ----------------------------------------------------------------------------
// drc_in_if
// Input channel of the digit record codec: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface drc_in_if;

  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  digit_0;
  logic [7:0]  digit_1;
  logic [7:0]  digit_2;
  logic [7:0]  digit_3;
  logic [7:0]  digit_4;
  logic [7:0]  digit_5;
  logic [63:0] record_in;

  modport source (
    output valid, mode, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5, record_in,
    input  ready
  );

  modport sink (
    input  valid, mode, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5, record_in,
    output ready
  );

endinterface

[src/drc_out_if.sv]
// ----------------------------------------------------------------------------
// drc_out_if
// Result channel of the digit record codec: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface drc_out_if;

  logic        valid;
  logic        ready;
  logic [63:0] record_out;
  logic [2:0]  status;
  logic [3:0]  out_digit_0;
  logic [3:0]  out_digit_1;
  logic [3:0]  out_digit_2;
  logic [3:0]  out_digit_3;
  logic [3:0]  out_digit_4;
  logic [3:0]  out_digit_5;

  modport source (
    output valid, record_out, status, out_digit_0, out_digit_1, out_digit_2,
           out_digit_3, out_digit_4, out_digit_5,
    input  ready
  );

  modport sink (
    input  valid, record_out, status, out_digit_0, out_digit_1, out_digit_2,
           out_digit_3, out_digit_4, out_digit_5,
    output ready
  );

endinterface

[src/drc_crc8.sv]
// ----------------------------------------------------------------------------
// drc_crc8
// CRC-8/ATM of six data bytes followed by the record marker, as an XOR tree.
// ----------------------------------------------------------------------------
module drc_crc8
  import drc_pkg::*;
(
  input  digits_t          data_i,
  output logic [ByteW-1:0] crc_o
);

  logic [DataW-1:0] flat;

  assign flat = data_i;

  always_comb begin
    crc_o = CrcMarkerTerm;
    for (int j = 0; j < DataW; j++) begin
      crc_o = crc_o ^ (flat[j] ? CrcCols[j] : '0);
    end
  end

endmodule

[src/drc_codec.sv]
// ----------------------------------------------------------------------------
// drc_codec
// Encode six digits into a record or decode and check a stored record.
// ----------------------------------------------------------------------------
module drc_codec
  import drc_pkg::*;
(
  input  in_t  item_i,
  output res_t res_o
);

  digits_t            data;
  digits_t            rec_digits;
  logic [ByteW-1:0]   crc;
  logic [ByteW-1:0]   rec_marker;
  logic [ByteW-1:0]   rec_crc;
  logic               digits_ok;

  assign rec_digits = item_i.record_in[DataW-1:0];
  assign rec_marker = item_i.record_in[DataW +: ByteW];
  assign rec_crc    = item_i.record_in[RecW-1 -: ByteW];
  assign data       = item_i.mode ? rec_digits : item_i.digit;

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (data[i] > DigitMax) begin
        digits_ok = 1'b0;
      end
    end
  end

  drc_crc8 u_crc (
    .data_i (data),
    .crc_o  (crc)
  );

  always_comb begin
    res_o.record_out = '0;
    res_o.status     = StOk;
    res_o.digit      = '0;
    if (!item_i.mode) begin
      if (!digits_ok) begin
        res_o.status = StBadArg;
      end else begin
        res_o.record_out = {crc, RecMarker, item_i.digit};
      end
    end else begin
      priority if (item_i.record_in == RecErased) begin
        res_o.status = StErased;
      end else if (rec_marker != RecMarker) begin
        res_o.status = StBadMarker;
      end else if (!digits_ok) begin
        res_o.status = StBadDigit;
      end else if (crc != rec_crc) begin
        res_o.status = StBadCrc;
      end else begin
        for (int i = 0; i < NumDigits; i++) begin
          res_o.digit[i] = rec_digits[i][DigitW-1:0];
        end
      end
    end
  end

endmodule

[src/digit_record_crc8_codec.sv]
// ----------------------------------------------------------------------------
// digit_record_crc8_codec
// Pack six decimal digits into a CRC-8 protected 64-bit record, or check one.
// ----------------------------------------------------------------------------
// Mode 0 builds the record (digits in bytes 0..5, marker 0xA5 in byte 6,
// CRC-8/ATM of bytes 0..6 in byte 7) or reports a digit above 9. Mode 1
// checks a stored record for the erased pattern, the marker, the digit range
// and the CRC in that priority and returns the digits on success. An item
// is taken into the input register, and its result is registered into the
// output register once that register is empty or being taken; one item is
// accepted every cycle while the result side keeps taking them.
module digit_record_crc8_codec
  import drc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  drc_in_if.sink           in_i,
  drc_out_if.source        out_o
);

  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  in_t  s1_d;
  in_t  s1_q;
  res_t res_d;
  res_t out_q;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign s1_d.mode      = in_i.mode;
  assign s1_d.digit     = {in_i.digit_5, in_i.digit_4, in_i.digit_3,
                           in_i.digit_2, in_i.digit_1, in_i.digit_0};
  assign s1_d.record_in = in_i.record_in;

  drc_codec u_codec (
    .item_i (s1_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.record_out  = out_q.record_out;
  assign out_o.status      = out_q.status;
  assign out_o.out_digit_0 = out_q.digit[0];
  assign out_o.out_digit_1 = out_q.digit[1];
  assign out_o.out_digit_2 = out_q.digit[2];
  assign out_o.out_digit_3 = out_q.digit[3];
  assign out_o.out_digit_4 = out_q.digit[4];
  assign out_o.out_digit_5 = out_q.digit[5];

endmodule
